// ----- hdl/sgr_pkg.sv -----
// sgr_pkg: shared types, codes and the palette for the SGR colour escape parser
// no dependencies; used by the interfaces and every module of the block

package sgr_pkg;

   localparam int CP_W     = 21;
   localparam int RGB_W    = 24;
   localparam int ALPHA_W  = 8;
   localparam int PARAM_W  = 8;
   localparam int PAL_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // code points the parser reacts to
   localparam logic [CP_W-1:0] ESCAPE_CODE_POINT = 21'd27;
   localparam logic [CP_W-1:0] ERROR_CODE_POINT  = 21'd65533;
   localparam logic [CP_W-1:0] CP_TAB       = 21'd9;
   localparam logic [CP_W-1:0] CP_NEWLINE   = 21'd10;
   localparam logic [CP_W-1:0] CP_SPACE     = 21'd32;
   localparam logic [CP_W-1:0] CP_SEMICOLON = 21'd59;
   localparam logic [CP_W-1:0] CP_LETTER_M  = 21'd109;
   localparam logic [CP_W-1:0] CP_BRACKET   = 21'd91;
   localparam logic [CP_W-1:0] CP_DIGIT_0   = 21'd48;
   localparam logic [CP_W-1:0] CP_DIGIT_9   = 21'd57;

   // sgr parameter values with a meaning
   localparam logic [PARAM_W-1:0] SGR_RESET      = 8'd0;
   localparam logic [PARAM_W-1:0] SGR_BOLD       = 8'd1;
   localparam logic [PARAM_W-1:0] SGR_NORMAL     = 8'd22;
   localparam logic [PARAM_W-1:0] SGR_FG_FIRST   = 8'd30;
   localparam logic [PARAM_W-1:0] SGR_FG_LAST    = 8'd37;
   localparam logic [PARAM_W-1:0] PARAM_SAT      = 8'd255;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_SEQ    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EV_GLYPH   = 2'd0,
      EV_SPACE   = 2'd1,
      EV_TAB     = 2'd2,
      EV_NEWLINE = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_TOP    = 3'd0,
      CSR_DEFAULT_BOTTOM = 3'd1,
      CSR_TOP_ALPHA      = 3'd2,
      CSR_BOTTOM_ALPHA   = 3'd3,
      CSR_HAS_ERROR      = 3'd4,
      CSR_HAS_SPACE      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RGB_W-1:0]   default_top;
      logic [RGB_W-1:0]   default_bottom;
      logic [ALPHA_W-1:0] alpha_top;
      logic [ALPHA_W-1:0] alpha_bottom;
      logic               has_error_glyph;
      logic               has_space_glyph;
   } cfg_type;

   // strobes that reload the running colours on a default colour write
   typedef struct packed {
      logic             top_load;
      logic             bottom_load;
      logic [RGB_W-1:0] colour;
   } colour_load_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            glyph_present;
   } req_word_type;

   typedef struct packed {
      event_type          event_res;
      logic [CP_W-1:0]    glyph;
      logic [RGB_W-1:0]   top_rgb;
      logic [ALPHA_W-1:0] top_alpha_out;
      logic [RGB_W-1:0]   bottom_colour;
      logic [ALPHA_W-1:0] bottom_alpha_out;
   } rsp_word_type;

   localparam logic [RGB_W-1:0] PALETTE_NORMAL [8] = '{
      24'h000000, 24'hCC0000, 24'h00CC00, 24'hCCCC00,
      24'h0000ED, 24'hCC00CC, 24'h00CCCC, 24'hBFBFBF
   };
   localparam logic [RGB_W-1:0] PALETTE_BOLD [8] = '{
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   function automatic logic [RGB_W-1:0] palette_colour(input logic bold,
                                                       input logic [PAL_W-1:0] idx);
      return bold ? PALETTE_BOLD[idx] : PALETTE_NORMAL[idx];
   endfunction

endpackage

// ----- hdl/sgr_if.sv -----
// sgr_if: valid/ready channel interfaces for requests, results and register writes
// depends on sgr_pkg for field widths

interface sgr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sgr_pkg::CP_W-1:0]    code_point;
   logic                        glyph_present;

   modport source (output valid, output code_point, output glyph_present, input ready);
   modport sink   (input valid, input code_point, input glyph_present, output ready);
endinterface

interface sgr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    event_res;
   logic [sgr_pkg::CP_W-1:0]      glyph;
   logic [sgr_pkg::RGB_W-1:0]     top_rgb;
   logic [sgr_pkg::ALPHA_W-1:0]   top_alpha_out;
   logic [sgr_pkg::RGB_W-1:0]     bottom_colour;
   logic [sgr_pkg::ALPHA_W-1:0]   bottom_alpha_out;

   modport source (output valid, output event_res, output glyph, output top_rgb,
                   output top_alpha_out, output bottom_colour, output bottom_alpha_out,
                   input ready);
   modport sink   (input valid, input event_res, input glyph, input top_rgb,
                   input top_alpha_out, input bottom_colour, input bottom_alpha_out,
                   output ready);
endinterface

interface sgr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sgr_pkg::CSR_IDX_W-1:0]    index;
   logic [sgr_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ansi_sgr_colour_parser_core.sv -----
// ansi_sgr_colour_parser_core: top level of the SGR colour escape parser
// depends on sgr_pkg, sgr_if, sgr_csr_regs and sgr_parser
//
//   channel   direction   carries
//   req_if    in          code_point, glyph_present
//   rsp_if    out         event_res, glyph, colours and alphas
//   csr_if    in          register index and write data, always ready
//
// one word per cycle while the result is not stalled: the input register feeds the decode,
// the result register holds its output; an accepted word passes through both in that order
// words that give no result (escape sequence parts, missing glyphs with no fallback) leave nothing
// synchronous reset returns the parse state, configuration registers and valid flags to their defaults
// a stalled result blocks only once the input register is also full

module ansi_sgr_colour_parser_core (
   input  logic          clock,
   input  logic          reset,
   sgr_req_if.sink       req_if,
   sgr_rsp_if.source     rsp_if,
   sgr_csr_if.sink       csr_if
);

   sgr_pkg::cfg_type          cfg;
   sgr_pkg::colour_load_type  colour_load;
   sgr_pkg::req_word_type     req_word;
   sgr_pkg::rsp_word_type     res_word;
   sgr_pkg::rsp_word_type     rsp_word_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      advance;
   logic                      held;
   logic                      res_fire;
   logic                      take;

   // configuration port
   assign csr_if.ready = 1'b1;

   sgr_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_if.valid),
      .wr_index    (csr_if.index),
      .wr_data     (csr_if.data),
      .cfg         (cfg),
      .colour_load (colour_load)
   );

   // pipeline flow
   assign advance      = ~rsp_valid_ff | rsp_if.ready;
   assign req_if.ready = ~held | advance;
   assign take         = req_if.valid & req_if.ready;
   assign req_word.code_point    = req_if.code_point;
   assign req_word.glyph_present = req_if.glyph_present;

   sgr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_word    (req_word),
      .advance     (advance),
      .cfg         (cfg),
      .colour_load (colour_load),
      .held        (held),
      .res_fire    (res_fire),
      .res_word    (res_word)
   );

   // result register
   assign rsp_valid_in = advance ? (held & res_fire) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_word_ff <= res_word;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.event_res        = rsp_word_ff.event_res;
   assign rsp_if.glyph            = rsp_word_ff.glyph;
   assign rsp_if.top_rgb          = rsp_word_ff.top_rgb;
   assign rsp_if.top_alpha_out    = rsp_word_ff.top_alpha_out;
   assign rsp_if.bottom_colour    = rsp_word_ff.bottom_colour;
   assign rsp_if.bottom_alpha_out = rsp_word_ff.bottom_alpha_out;

endmodule

// ----- hdl/sgr_csr_regs.sv -----
// sgr_csr_regs: configuration registers written through the csr channel
// depends on sgr_pkg; feeds the parser with settings and colour reload strobes

module sgr_csr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [sgr_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]  wr_data,
   output sgr_pkg::cfg_type                cfg,
   output sgr_pkg::colour_load_type        colour_load
);

   sgr_pkg::cfg_type cfg_ff;
   sgr_pkg::cfg_type cfg_in;
   logic             top_hit;
   logic             bottom_hit;

   // register decode
   always_comb begin
      cfg_in     = cfg_ff;
      top_hit    = 1'b0;
      bottom_hit = 1'b0;
      if (wr_en) begin
         unique case (wr_index)
            sgr_pkg::CSR_DEFAULT_TOP: begin
               cfg_in.default_top = wr_data;
               top_hit = 1'b1;
            end
            sgr_pkg::CSR_DEFAULT_BOTTOM: begin
               cfg_in.default_bottom = wr_data;
               bottom_hit = 1'b1;
            end
            sgr_pkg::CSR_TOP_ALPHA:    cfg_in.alpha_top       = wr_data[sgr_pkg::ALPHA_W-1:0];
            sgr_pkg::CSR_BOTTOM_ALPHA: cfg_in.alpha_bottom    = wr_data[sgr_pkg::ALPHA_W-1:0];
            sgr_pkg::CSR_HAS_ERROR:    cfg_in.has_error_glyph = wr_data[0];
            sgr_pkg::CSR_HAS_SPACE:    cfg_in.has_space_glyph = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_top     <= '1;
         cfg_ff.default_bottom  <= '1;
         cfg_ff.alpha_top       <= '1;
         cfg_ff.alpha_bottom    <= '1;
         cfg_ff.has_error_glyph <= 1'b1;
         cfg_ff.has_space_glyph <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg                     = cfg_ff;
   assign colour_load.top_load    = top_hit;
   assign colour_load.bottom_load = bottom_hit;
   assign colour_load.colour      = wr_data;

endmodule

// ----- hdl/sgr_parser.sv -----
// sgr_parser: input register, escape sequence state and the per-word decode
// depends on sgr_pkg; settings come from sgr_csr_regs

module sgr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  sgr_pkg::req_word_type     req_word,
   input  logic                      advance,
   input  sgr_pkg::cfg_type          cfg,
   input  sgr_pkg::colour_load_type  colour_load,
   output logic                      held,
   output logic                      res_fire,
   output sgr_pkg::rsp_word_type     res_word
);

   // input register
   logic                   held_ff;
   logic                   held_in;
   sgr_pkg::req_word_type  word_ff;

   // parse state
   sgr_pkg::mode_type              mode_ff, mode_in;
   logic [sgr_pkg::PARAM_W-1:0]    param_ff, param_in;
   logic                           bold_ff, bold_in;
   logic [sgr_pkg::PAL_W-1:0]      pal_ff, pal_in;
   logic [sgr_pkg::RGB_W-1:0]      top_ff, top_in;
   logic [sgr_pkg::RGB_W-1:0]      bottom_ff, bottom_in;

   logic                           consume;
   logic [sgr_pkg::CP_W-1:0]       cp;
   logic                           is_digit;
   logic                           is_apply;
   logic [11:0]                    acc;
   logic [sgr_pkg::PARAM_W-1:0]    fg_offset;
   sgr_pkg::rsp_word_type          print_word;
   logic                           print_fire;
   sgr_pkg::rsp_word_type          space_word;
   sgr_pkg::rsp_word_type          ctrl_word;

   assign consume = held_ff & advance;
   assign held_in = take | (held_ff & ~advance);
   assign held    = held_ff;
   assign cp      = word_ff.code_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
      if (take) begin
         word_ff <= req_word;
      end
   end

   // digit accumulate: p * 10 + d, digits 0x30..0x39 carry their value in the low nibble
   assign is_digit  = (cp >= sgr_pkg::CP_DIGIT_0) && (cp <= sgr_pkg::CP_DIGIT_9);
   assign is_apply  = (cp == sgr_pkg::CP_SEMICOLON) || (cp == sgr_pkg::CP_LETTER_M);
   assign acc       = {1'b0, param_ff, 3'b000} + {3'b000, param_ff, 1'b0} + {8'h00, cp[3:0]};
   assign fg_offset = param_ff - sgr_pkg::SGR_FG_FIRST;

   // printable word with font fallback
   always_comb begin
      print_word.event_res        = sgr_pkg::EV_GLYPH;
      print_word.glyph            = cp;
      print_word.top_rgb          = top_ff;
      print_word.top_alpha_out    = cfg.alpha_top;
      print_word.bottom_colour    = bottom_ff;
      print_word.bottom_alpha_out = cfg.alpha_bottom;
      print_fire                  = 1'b1;
      if (!word_ff.glyph_present) begin
         if (cfg.has_error_glyph) begin
            print_word.glyph = sgr_pkg::ERROR_CODE_POINT;
         end else if (cfg.has_space_glyph) begin
            print_word.glyph = sgr_pkg::CP_SPACE;
         end else begin
            print_fire = 1'b0;
         end
      end
   end

   always_comb begin
      space_word           = print_word;
      space_word.event_res = sgr_pkg::EV_SPACE;
      space_word.glyph     = sgr_pkg::CP_SPACE;
      ctrl_word            = '0;
   end

   // next state and result
   always_comb begin
      mode_in   = mode_ff;
      param_in  = param_ff;
      bold_in   = bold_ff;
      pal_in    = pal_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      res_fire  = 1'b0;
      res_word  = print_word;
      unique case (mode_ff)
         sgr_pkg::MODE_SEQ: begin
            if (is_apply) begin
               param_in = '0;
               if (cp == sgr_pkg::CP_LETTER_M) begin
                  mode_in = sgr_pkg::MODE_NORMAL;
               end
               if (param_ff == sgr_pkg::SGR_RESET) begin
                  bold_in   = 1'b0;
                  pal_in    = '0;
                  top_in    = cfg.default_top;
                  bottom_in = cfg.default_bottom;
               end else if (param_ff == sgr_pkg::SGR_BOLD) begin
                  bold_in   = 1'b1;
                  top_in    = sgr_pkg::palette_colour(1'b1, pal_ff);
                  bottom_in = top_in;
               end else if (param_ff == sgr_pkg::SGR_NORMAL) begin
                  bold_in   = 1'b0;
                  top_in    = sgr_pkg::palette_colour(1'b0, pal_ff);
                  bottom_in = top_in;
               end else if ((param_ff >= sgr_pkg::SGR_FG_FIRST) &&
                            (param_ff <= sgr_pkg::SGR_FG_LAST)) begin
                  pal_in    = fg_offset[sgr_pkg::PAL_W-1:0];
                  top_in    = sgr_pkg::palette_colour(bold_ff, pal_in);
                  bottom_in = top_in;
               end
            end else if (is_digit) begin
               param_in = (acc > {4'h0, sgr_pkg::PARAM_SAT}) ? sgr_pkg::PARAM_SAT
                                                              : acc[sgr_pkg::PARAM_W-1:0];
            end
         end
         sgr_pkg::MODE_ESC: begin
            if (cp == sgr_pkg::CP_BRACKET) begin
               mode_in  = sgr_pkg::MODE_SEQ;
               param_in = '0;
            end else begin
               mode_in  = sgr_pkg::MODE_NORMAL;
               res_fire = print_fire;
            end
         end
         default: begin
            mode_in = sgr_pkg::MODE_NORMAL;
            if (cp == sgr_pkg::CP_NEWLINE) begin
               res_fire           = 1'b1;
               res_word           = ctrl_word;
               res_word.event_res = sgr_pkg::EV_NEWLINE;
            end else if (cp == sgr_pkg::CP_SPACE) begin
               res_fire = 1'b1;
               res_word = space_word;
            end else if (cp == sgr_pkg::CP_TAB) begin
               res_fire           = 1'b1;
               res_word           = ctrl_word;
               res_word.event_res = sgr_pkg::EV_TAB;
            end else if (cp == sgr_pkg::ESCAPE_CODE_POINT) begin
               mode_in = sgr_pkg::MODE_ESC;
            end else begin
               res_fire = print_fire;
            end
         end
      endcase
   end

   // state register; a default colour write reloads the running colour
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sgr_pkg::MODE_NORMAL;
         param_ff  <= '0;
         bold_ff   <= 1'b0;
         pal_ff    <= '0;
         top_ff    <= '1;
         bottom_ff <= '1;
      end else begin
         if (consume) begin
            mode_ff   <= mode_in;
            param_ff  <= param_in;
            bold_ff   <= bold_in;
            pal_ff    <= pal_in;
            top_ff    <= top_in;
            bottom_ff <= bottom_in;
         end
         if (colour_load.top_load) begin
            top_ff <= colour_load.colour;
         end
         if (colour_load.bottom_load) begin
            bottom_ff <= colour_load.colour;
         end
      end
   end

endmodule

// ----- hdl/sgr_checker.sv -----
// sgr_checker: port-level assertions for the SGR colour escape parser
// depends on sgr_pkg; bound to ansi_sgr_colour_parser_core below

module sgr_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_event,
   input  logic [sgr_pkg::CP_W-1:0]      rsp_glyph,
   input  logic [sgr_pkg::RGB_W-1:0]     rsp_top_colour,
   input  logic [sgr_pkg::ALPHA_W-1:0]   rsp_top_alpha,
   input  logic [sgr_pkg::RGB_W-1:0]     rsp_bottom_colour,
   input  logic [sgr_pkg::ALPHA_W-1:0]   rsp_bottom_alpha
);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_glyph))
      else $error("stalled result dropped or changed");

   // tab and newline carry no glyph and no colour
   a_ctrl_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event == sgr_pkg::EV_TAB || rsp_event == sgr_pkg::EV_NEWLINE)
      |-> rsp_glyph == '0 && rsp_top_colour == '0 && rsp_bottom_colour == '0 &&
          rsp_top_alpha == '0 && rsp_bottom_alpha == '0)
      else $error("control event with payload");

   // a space event always draws the space glyph
   a_space_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event == sgr_pkg::EV_SPACE |-> rsp_glyph == sgr_pkg::CP_SPACE)
      else $error("space event with other glyph");

endmodule

bind ansi_sgr_colour_parser_core sgr_checker u_sgr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_event         (rsp_if.event_res),
   .rsp_glyph         (rsp_if.glyph),
   .rsp_top_colour    (rsp_if.top_rgb),
   .rsp_top_alpha     (rsp_if.top_alpha_out),
   .rsp_bottom_colour (rsp_if.bottom_colour),
   .rsp_bottom_alpha  (rsp_if.bottom_alpha_out)
);
